[src/pcpt_pkg.sv]
package pcpt_pkg;
  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned IoWidth           = 32;
  localparam int unsigned PoseDepth         = 12;
  localparam int unsigned PoseIdxWidth      = 4;
  localparam logic [IoWidth-1:0] MountOffsetReset = 32'sd13107;
  localparam logic KindPoint = 1'b0;
  localparam logic KindPose  = 1'b1;
endpackage

[src/pose_chain_point_transform.sv]
// Pose chaining and point transform, signed fixed point (VALUE_WIDTH bits, FRAC_BITS fraction).
// One multiply-accumulate unit does every product, one per cycle within a dot product. A
// dot product has 3 products, a drain step and rounding. A point beat takes 3 dot products
// plus a hand-off into the output register. Input ready returns in the same cycle that the
// result turns valid, unless the previous result beat is still held. In that case the
// finished point waits until the output register is free.
// Pose rows 0 and 1 are only stored, with no work. Row 2 chains the pose (3 dot products for
// R^T t, 9 for the rotation, 3 for the translation) and rebuilds the mounted pose with one
// more dot product. After reset the mounted pose is built before input ready rises. Input
// ready is low while an item is in work.
// The mount offset register takes effect at the next completed pose.
module pose_chain_point_transform #(
  parameter int unsigned FRAC_BITS   = pcpt_pkg::FracBitsDefault,
  parameter int unsigned VALUE_WIDTH = pcpt_pkg::ValueWidthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pcpt_pkg::IoWidth-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [1:0]                 row_i,
  input  logic signed [pcpt_pkg::IoWidth-1:0] first_value_i,
  input  logic signed [pcpt_pkg::IoWidth-1:0] second_value_i,
  input  logic signed [pcpt_pkg::IoWidth-1:0] third_value_i,
  input  logic signed [pcpt_pkg::IoWidth-1:0] fourth_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [pcpt_pkg::IoWidth-1:0] global_x_o,
  output logic signed [pcpt_pkg::IoWidth-1:0] global_y_o,
  output logic signed [pcpt_pkg::IoWidth-1:0] global_z_o
);
  import pcpt_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned AW  = 2 * W + 4;

  typedef logic signed [W-1:0] val_t;
  typedef logic signed [AW-1:0] acc_t;

  typedef enum logic [2:0] {
    StIdle, StPoint, StChainU, StChainR, StChainT, StBuild, StOut
  } state_e;

  function automatic val_t sat_w(input acc_t a);
    acc_t maxv, minv;
    maxv = acc_t'({1'b0, {(W-1){1'b1}}});
    minv = -maxv - acc_t'(1);
    if (a > maxv) return val_t'(maxv);
    if (a < minv) return val_t'(minv);
    return val_t'(a);
  endfunction

  function automatic val_t sat_in(input logic signed [IoWidth-1:0] x);
    return sat_w(acc_t'(x));
  endfunction

  function automatic logic signed [IoWidth-1:0] sat_out(input val_t x);
    logic signed [W+IoWidth-1:0] e, maxv, minv;
    e    = (W+IoWidth)'(x);
    maxv = (W+IoWidth)'({1'b0, {(IoWidth-1){1'b1}}});
    minv = -maxv - (W+IoWidth)'(1);
    if (e > maxv) return IoWidth'(maxv);
    if (e < minv) return IoWidth'(minv);
    return IoWidth'(e);
  endfunction

  state_e state_q;
  val_t g_q [PoseDepth];
  val_t s_q [PoseDepth];
  val_t c_q [PoseDepth];
  val_t u_q [3];
  val_t nr_q [9];
  val_t p_q [3];
  logic signed [IoWidth-1:0] off_q;
  logic [3:0] dot_q;
  logic [1:0] k_q;
  acc_t acc_q;
  logic signed [PW-1:0] prod_q;
  logic       prod_v_q;
  logic signed [IoWidth-1:0] res_q [3];
  logic signed [IoWidth-1:0] out_q [3];
  logic       out_v_q;

  val_t ma, mb, addend;
  logic neg;
  val_t one_v;
  assign one_v = val_t'(1) <<< FRAC_BITS;

  // operand selection for the shared multiplier
  always_comb begin
    logic [1:0] i, j;
    ma = '0; mb = '0; addend = '0; neg = 1'b0;
    i = dot_q[3:2] == 2'd3 ? 2'd0 : dot_q[3:2];
    j = dot_q[1:0] == 2'd3 ? 2'd0 : dot_q[1:0];
    case (state_q)
      StPoint: begin
        ma = c_q[PoseIdxWidth'(3*dot_q[1:0] + k_q)];
        mb = p_q[k_q];
        addend = c_q[PoseIdxWidth'(9 + dot_q[1:0])];
      end
      StChainU: begin
        ma = s_q[PoseIdxWidth'(3*k_q + dot_q[1:0])];
        mb = s_q[PoseIdxWidth'(9 + k_q)];
      end
      StChainR: begin
        ma = g_q[PoseIdxWidth'(3*i + k_q)];
        mb = s_q[PoseIdxWidth'(3*j + k_q)];
      end
      StChainT: begin
        ma = g_q[PoseIdxWidth'(3*dot_q[1:0] + k_q)];
        mb = u_q[k_q];
        addend = g_q[PoseIdxWidth'(9 + dot_q[1:0])];
        neg = 1'b1;
      end
      StBuild: begin
        ma = (k_q == 2'd0) ? one_v : '0;
        mb = (k_q == 2'd0) ? g_q[11] : '0;
        addend = sat_in(off_q);
      end
      default: ;
    endcase
  end

  acc_t rounded;
  val_t dot_res;
  assign rounded = (acc_q + (acc_t'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  assign dot_res = sat_w(rounded);

  val_t neg_g [PoseDepth];
  always_comb begin
    for (int n = 0; n < PoseDepth; n++) neg_g[n] = sat_w(-acc_t'(g_q[n]));
  end

  logic accept;
  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StBuild;
      off_q   <= MountOffsetReset;
      dot_q   <= '0;
      k_q     <= '0;
      prod_v_q <= 1'b0;
      out_v_q <= 1'b0;
      acc_q   <= '0;
      for (int n = 0; n < PoseDepth; n++) g_q[n] <= '0;
      g_q[0] <= val_t'(1) <<< FRAC_BITS;
      g_q[4] <= val_t'(1) <<< FRAC_BITS;
      g_q[8] <= val_t'(1) <<< FRAC_BITS;
    end else begin
      if (cfg_we_i) off_q <= cfg_wdata_i;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      prod_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            dot_q <= '0; k_q <= '0;
            if (kind_i == KindPoint) begin
              p_q[0] <= sat_in(first_value_i);
              p_q[1] <= sat_in(second_value_i);
              p_q[2] <= sat_in(third_value_i);
              state_q <= StPoint;
            end else if (row_i != 2'd3) begin
              s_q[PoseIdxWidth'(3*row_i)]     <= sat_in(first_value_i);
              s_q[PoseIdxWidth'(3*row_i + 1)] <= sat_in(second_value_i);
              s_q[PoseIdxWidth'(3*row_i + 2)] <= sat_in(third_value_i);
              s_q[PoseIdxWidth'(9 + row_i)]   <= sat_in(fourth_value_i);
              if (row_i == 2'd2) state_q <= StChainU;
            end
          end
        end
        StOut: begin
          if (!out_v_q) begin
            for (int n = 0; n < 3; n++) out_q[n] <= res_q[n];
            out_v_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: begin
          // k 0..2 issues products, 3 drains, then rounding
          if (k_q == 2'd0 && !prod_v_q)
            acc_q <= acc_t'(addend) <<< FRAC_BITS;
          if (k_q != 2'd3) begin
            prod_q   <= PW'(ma) * PW'(mb);
            prod_v_q <= 1'b1;
            k_q      <= k_q + 2'd1;
          end
          if (prod_v_q) begin
            if (k_q == 2'd1)
              acc_q <= (acc_t'(addend) <<< FRAC_BITS)
                       + (neg ? -acc_t'(prod_q) : acc_t'(prod_q));
            else
              acc_q <= acc_q + (neg ? -acc_t'(prod_q) : acc_t'(prod_q));
          end
          if (k_q == 2'd3 && !prod_v_q) begin
            k_q <= '0;
            dot_q <= dot_q + 4'd1;
            case (state_q)
              StPoint: begin
                res_q[dot_q[1:0]] <= sat_out(dot_res);
                if (dot_q == 4'd2) state_q <= StOut;
              end
              StChainU: begin
                u_q[dot_q[1:0]] <= dot_res;
                if (dot_q == 4'd2) begin
                  dot_q <= '0; state_q <= StChainR;
                end
              end
              StChainR: begin
                nr_q[PoseIdxWidth'(3*dot_q[3:2] + dot_q[1:0])] <= dot_res;
                if (dot_q[1:0] == 2'd2) dot_q <= {dot_q[3:2] + 2'd1, 2'd0};
                if (dot_q == 4'b1010) begin
                  dot_q <= '0; state_q <= StChainT;
                end
              end
              StChainT: begin
                g_q[PoseIdxWidth'(9 + dot_q[1:0])] <= dot_res;
                if (dot_q == 4'd2) begin
                  for (int n = 0; n < 9; n++) g_q[n] <= nr_q[n];
                  dot_q <= '0; state_q <= StBuild;
                end
              end
              default: begin
                for (int n = 0; n < 3; n++) begin
                  c_q[n]     <= g_q[6+n];
                  c_q[3+n]   <= neg_g[n];
                  c_q[6+n]   <= neg_g[3+n];
                end
                c_q[9]  <= dot_res;
                c_q[10] <= neg_g[9];
                c_q[11] <= neg_g[10];
                dot_q   <= '0;
                state_q <= StIdle;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign global_x_o  = out_q[0];
  assign global_y_o  = out_q[1];
  assign global_z_o  = out_q[2];

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_out_from_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q) == StOut) else $error("result without point");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(global_x_o) && $stable(global_y_o)
    && $stable(global_z_o)) else $error("result beat changed while waiting");
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pcpt_pkg::*;

  localparam logic [1:0] RowIgnored = 2'd3;
  localparam int unsigned Frac = 16;
  localparam longint One = 64'sd1 <<< Frac;
  localparam logic [31:0] OneBits = 32'h0001_0000;
  localparam int SettleCycles = 150;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  class pose_scoreboard;
    longint global_pose[12];
    longint staged_pose[12];
    longint mounted_pose[12];
    longint offset_x;
    point_t expected_points[$];
    int errors;

    function new();
      errors = 0;
      offset_x = 13107;
      foreach (global_pose[i]) begin
        global_pose[i] = 0;
        staged_pose[i] = 0;
      end
      global_pose[0] = One;
      global_pose[4] = One;
      global_pose[8] = One;
      rebuild_mounted();
    endfunction

    function longint sat32(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 64'sd2147483647;
      if (v < -128'sd2147483648) return -64'sd2147483648;
      return longint'(v);
    endfunction

    function longint neg_sat(longint v);
      logic signed [127:0] w;
      w = 128'(v);
      return sat32(-w);
    endfunction

    function longint mac3(longint a0, longint a1, longint a2, longint b0, longint b1,
                          longint b2, longint addend, bit negate);
      logic signed [127:0] acc, sum;
      logic signed [127:0] x0, x1, x2, y0, y1, y2;
      x0 = 128'(a0); x1 = 128'(a1); x2 = 128'(a2);
      y0 = 128'(b0); y1 = 128'(b1); y2 = 128'(b2);
      acc = 128'(addend);
      acc = acc <<< Frac;
      sum = x0 * y0 + x1 * y1 + x2 * y2;
      acc = negate ? acc - sum : acc + sum;
      acc = (acc + (128'sd1 <<< (Frac - 1))) >>> Frac;
      return sat32(acc);
    endfunction

    function void rebuild_mounted();
      for (int j = 0; j < 3; j++) begin
        mounted_pose[j] = global_pose[6 + j];
        mounted_pose[3 + j] = neg_sat(global_pose[j]);
        mounted_pose[6 + j] = neg_sat(global_pose[3 + j]);
      end
      mounted_pose[9] = mac3(One, 0, 0, global_pose[11], 0, 0, offset_x, 1'b0);
      mounted_pose[10] = neg_sat(global_pose[9]);
      mounted_pose[11] = neg_sat(global_pose[10]);
    endfunction

    function void chain_relative();
      longint u[3], nr[9], nt[3];
      for (int i = 0; i < 3; i++)
        u[i] = mac3(staged_pose[i], staged_pose[3 + i], staged_pose[6 + i],
                    staged_pose[9], staged_pose[10], staged_pose[11], 0, 1'b0);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++)
          nr[i * 3 + j] = mac3(global_pose[i * 3], global_pose[i * 3 + 1],
                               global_pose[i * 3 + 2], staged_pose[j * 3],
                               staged_pose[j * 3 + 1], staged_pose[j * 3 + 2], 0, 1'b0);
        nt[i] = mac3(global_pose[i * 3], global_pose[i * 3 + 1], global_pose[i * 3 + 2],
                     u[0], u[1], u[2], global_pose[9 + i], 1'b1);
      end
      for (int i = 0; i < 9; i++) global_pose[i] = nr[i];
      for (int i = 0; i < 3; i++) global_pose[9 + i] = nt[i];
      rebuild_mounted();
    endfunction

    function void note_input(logic kind, logic [1:0] row, longint a, longint b, longint c,
                             longint d);
      point_t p;
      longint r[3];
      if (kind == KindPose) begin
        if (row == RowIgnored) return;
        staged_pose[row * 3] = a;
        staged_pose[row * 3 + 1] = b;
        staged_pose[row * 3 + 2] = c;
        staged_pose[9 + row] = d;
        if (row == 2'd2) chain_relative();
        return;
      end
      for (int i = 0; i < 3; i++)
        r[i] = mac3(mounted_pose[i * 3], mounted_pose[i * 3 + 1], mounted_pose[i * 3 + 2],
                    a, b, c, mounted_pose[9 + i], 1'b0);
      p.x = r[0][31:0];
      p.y = r[1][31:0];
      p.z = r[2][31:0];
      expected_points = {expected_points, p};
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_t p;
      if (expected_points.size() == 0) begin
        $error("unexpected result beat x=%h y=%h z=%h", x, y, z);
        errors++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.x) begin $error("global_x expected %h got %h", p.x, x); errors++; end
      if (y !== p.y) begin $error("global_y expected %h got %h", p.y, y); errors++; end
      if (z !== p.z) begin $error("global_z expected %h got %h", p.z, z); errors++; end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IoWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = 1'b0;
  logic [1:0] row_i = '0;
  logic signed [IoWidth-1:0] first_value_i = '0;
  logic signed [IoWidth-1:0] second_value_i = '0;
  logic signed [IoWidth-1:0] third_value_i = '0;
  logic signed [IoWidth-1:0] fourth_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [IoWidth-1:0] global_x_o, global_y_o, global_z_o;

  pose_scoreboard sb;
  bit calm = 1'b0;

  pose_chain_point_transform dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .kind_i, .row_i,
    .first_value_i, .second_value_i, .third_value_i, .fourth_value_i, .out_valid_o,
    .out_ready_i, .global_x_o, .global_y_o, .global_z_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_beat(logic kind, logic [1:0] row, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
    if (!calm) begin
      while ($urandom_range(0, 99) < 27) begin
        in_valid_i = 1'b0;
        kind_i = 1'($urandom);
        first_value_i = $urandom;
        @(negedge clk_i);
      end
    end
    kind_i = kind;
    row_i = row;
    first_value_i = a;
    second_value_i = b;
    third_value_i = c;
    fourth_value_i = d;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(kind, row, longint'(signed'(a)), longint'(signed'(b)),
                  longint'(signed'(c)), longint'(signed'(d)));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.expected_points.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_offset(logic [31:0] v);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.offset_x = longint'(signed'(v));
  endtask

  function automatic logic [31:0] near_unit(bit on);
    return on ? OneBits + $urandom_range(0, 4000) - 2000 : $urandom_range(0, 4000) - 2000;
  endfunction

  // near-orthonormal relative pose: signed permutation plus small noise, or random values when wild
  task automatic send_relative_pose(bit wild);
    int shift;
    bit flip;
    logic [31:0] v[3];
    shift = $urandom_range(0, 2);
    flip = $urandom;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        v[k] = wild ? $urandom : near_unit(k == (flip ? (shift - r + 3) % 3 : (r + shift) % 3));
        if (!wild && $urandom_range(0, 1)) v[k] = -v[k];
      end
      send_beat(KindPose, r[1:0], v[0], v[1], v[2],
                wild ? $urandom : $urandom_range(0, 1 << 20) - (1 << 19));
    end
  endtask

  task automatic send_point(bit wild);
    if (wild) send_beat(KindPoint, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    else send_beat(KindPoint, 2'($urandom), $urandom_range(0, 1 << 24) - (1 << 23),
                   $urandom_range(0, 1 << 24) - (1 << 23),
                   $urandom_range(0, 1 << 24) - (1 << 23), $urandom);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(global_x_o, global_y_o, global_z_o);
      @(negedge clk_i);
      out_ready_i <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [31:0] offsets[4];
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: default mount, extremes, ignored row, pose chaining
    send_beat(KindPoint, 2'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
    send_beat(KindPoint, 2'd3, 32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff);
    send_beat(KindPoint, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_beat(KindPoint, 2'd2, OneBits, -OneBits, 32'h1, 32'h7fffffff);
    send_beat(KindPose, RowIgnored, 32'h7fffffff, 32'h80000000, 32'h1, 32'h2);
    send_beat(KindPose, 2'd0, OneBits, 0, 0, OneBits);
    send_beat(KindPose, 2'd1, 0, OneBits, 0, -OneBits);
    send_beat(KindPose, 2'd2, 0, 0, OneBits, 32'h8000);
    send_beat(KindPoint, 2'd0, OneBits, 2 * OneBits, 3 * OneBits, 0);
    send_beat(KindPose, 2'd0, 32'h80000000, 32'h7fffffff, 0, 32'h80000000);
    send_beat(KindPose, 2'd1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_beat(KindPose, 2'd2, 32'h80000000, 0, 32'h7fffffff, 32'h80000000);
    send_beat(KindPoint, 2'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send_beat(KindPoint, 2'd0, OneBits, OneBits, OneBits, 0);
    write_offset(32'h80000000);
    send_beat(KindPoint, 2'd0, OneBits, OneBits, OneBits, 0);
    send_relative_pose(1'b0);
    send_beat(KindPoint, 2'd0, OneBits, OneBits, OneBits, 0);

    offsets[0] = 32'h7fffffff;
    offsets[1] = 32'h0;
    offsets[2] = 32'h80000000;
    offsets[3] = $urandom;
    for (int ph = 0; ph < 4; ph++) begin
      write_offset(offsets[ph]);
      // identity pose rebuilds the mounted pose with the new offset, leaving the chain unchanged
      send_beat(KindPose, 2'd0, OneBits, 0, 0, 0);
      send_beat(KindPose, 2'd1, 0, OneBits, 0, 0);
      send_beat(KindPose, 2'd2, 0, 0, OneBits, 0);
      for (int n = 0; n < 185; n++) begin
        int pick;
        calm = (ph == 1) && (n >= 40) && (n < 140);
        if (ph == 2 && n == 100) drain();
        pick = $urandom_range(0, 99);
        if (pick < 12) send_relative_pose($urandom_range(0, 9) == 0);
        else if (pick < 16) send_beat(KindPose, RowIgnored, $urandom, $urandom, $urandom,
                                      $urandom);
        else if (pick < 20) send_beat(KindPose, 2'($urandom_range(0, 1)), near_unit(1'b1),
                                      near_unit(1'b0), near_unit(1'b0), $urandom);
        else send_point($urandom_range(0, 99) < 15);
      end
      calm = 1'b0;
    end

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
